// ----- src/dpfr_pkg.sv -----
// shared types, codes and constants of the dual-protocol frame receiver
package dpfr_pkg;

    localparam int STORE_BYTES_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int DATA_W          = 16;
    localparam int LIMIT_W         = 7;
    localparam int CFG_IDX_W       = 3;
    localparam int HEX_PAY_OFS     = 3;
    localparam int HEX_OVERHEAD    = 5;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HEX    = 2'd1,
        KIND_TEXT   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_HEX_OK   = 3'd2,
        ST_TEXT_OK  = 3'd3,
        ST_HEAD_ERR = 3'd4,
        ST_HEX_ERR  = 3'd5,
        ST_TEXT_ERR = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_HEX_START        = 3'd0,
        IDX_HEX_SECOND_START = 3'd1,
        IDX_HEX_TAIL_FIRST   = 3'd2,
        IDX_HEX_TAIL_LAST    = 3'd3,
        IDX_TEXT_START       = 3'd4,
        IDX_TEXT_TAIL_FIRST  = 3'd5,
        IDX_TEXT_TAIL_LAST   = 3'd6,
        IDX_FRAME_LIMIT      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  hex_start;
        logic [BYTE_W-1:0]  hex_second_start;
        logic [BYTE_W-1:0]  hex_tail_first;
        logic [BYTE_W-1:0]  hex_tail_last;
        logic [BYTE_W-1:0]  text_start;
        logic [BYTE_W-1:0]  text_tail_first;
        logic [BYTE_W-1:0]  text_tail_last;
        logic [LIMIT_W-1:0] frame_limit;
    } cfg_t;

    localparam logic [BYTE_W-1:0]  RST_HEX_START        = 8'hFF;
    localparam logic [BYTE_W-1:0]  RST_HEX_SECOND_START = 8'hAA;
    localparam logic [BYTE_W-1:0]  RST_HEX_TAIL_FIRST   = 8'h55;
    localparam logic [BYTE_W-1:0]  RST_HEX_TAIL_LAST    = 8'hFE;
    localparam logic [BYTE_W-1:0]  RST_TEXT_START       = 8'h40;
    localparam logic [BYTE_W-1:0]  RST_TEXT_TAIL_FIRST  = 8'h24;
    localparam logic [BYTE_W-1:0]  RST_TEXT_TAIL_LAST   = 8'h23;
    localparam logic [LIMIT_W-1:0] RST_FRAME_LIMIT      = 7'd64;

endpackage

// ----- src/dual_protocol_frame_receiver.sv -----
// top level of the dual-protocol frame receiver
//
// Collects binary frames (start, second start, length, payload, two tail bytes) and text
// frames (start character, payload, two tail characters) in a byte store. An ordinary byte
// gives one status beat: wait, busy, or an error at the frame limit. The final tail byte
// of a frame starts a walk of the store through its single read port: a binary frame gets
// a check step, then reads both bytes of each 16-bit word and emits the word; a text frame
// finds its first tail character, checks the character after it, then reads and emits each
// payload byte. Each frame ends with one status beat; result backpressure stalls the walk.
// No byte is taken while the walk runs. The store needs no clearing after reset.
module dual_protocol_frame_receiver
    import dpfr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [1:0]           kind,
    output logic [DATA_W-1:0]    data,
    output logic [2:0]           status,
    output logic                 last
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int CNT_W  = $clog2(STORE_BYTES + 1);

    cfg_t              cfg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    dpfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dpfr_store #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dpfr_ctrl #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .kind      (kind),
        .data      (data),
        .status    (status),
        .last      (last),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

// ----- src/dpfr_cfg.sv -----
// configuration register file of the frame receiver
module dpfr_cfg
    import dpfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hex_start        <= RST_HEX_START;
            cfg_reg.hex_second_start <= RST_HEX_SECOND_START;
            cfg_reg.hex_tail_first   <= RST_HEX_TAIL_FIRST;
            cfg_reg.hex_tail_last    <= RST_HEX_TAIL_LAST;
            cfg_reg.text_start       <= RST_TEXT_START;
            cfg_reg.text_tail_first  <= RST_TEXT_TAIL_FIRST;
            cfg_reg.text_tail_last   <= RST_TEXT_TAIL_LAST;
            cfg_reg.frame_limit      <= RST_FRAME_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                IDX_HEX_START:        cfg_reg.hex_start        <= cfg_data;
                IDX_HEX_SECOND_START: cfg_reg.hex_second_start <= cfg_data;
                IDX_HEX_TAIL_FIRST:   cfg_reg.hex_tail_first   <= cfg_data;
                IDX_HEX_TAIL_LAST:    cfg_reg.hex_tail_last    <= cfg_data;
                IDX_TEXT_START:       cfg_reg.text_start       <= cfg_data;
                IDX_TEXT_TAIL_FIRST:  cfg_reg.text_tail_first  <= cfg_data;
                IDX_TEXT_TAIL_LAST:   cfg_reg.text_tail_last   <= cfg_data;
                IDX_FRAME_LIMIT:      cfg_reg.frame_limit      <= cfg_data[LIMIT_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/dpfr_store.sv -----
// frame byte store: one write port, one read port with registered data
module dpfr_store
    import dpfr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int ADDR_W      = $clog2(STORE_BYTES)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/dpfr_ctrl.sv -----
// receive sequencer, frame checks, store walk and result register
module dpfr_ctrl
    import dpfr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int ADDR_W      = $clog2(STORE_BYTES),
    parameter int CNT_W       = $clog2(STORE_BYTES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [1:0]        kind,
    output logic [DATA_W-1:0] data,
    output logic [2:0]        status,
    output logic              last,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [BYTE_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [BYTE_W-1:0] mem_rdata
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'h0001,
        S_HEX_RX   = 13'h0002,
        S_TEXT_RX  = 13'h0004,
        S_HEX_CHK  = 13'h0008,
        S_HEX_RDH  = 13'h0010,
        S_HEX_RDL  = 13'h0020,
        S_HEX_EMIT = 13'h0040,
        S_TXT_RD   = 13'h0080,
        S_TXT_CMP  = 13'h0100,
        S_TXT_CMP2 = 13'h0200,
        S_TXT_ERD  = 13'h0400,
        S_TXT_EMIT = 13'h0800,
        S_FIN      = 13'h1000
    } state_t;

    localparam logic [LIMIT_W-1:0] STORE_LIMIT = LIMIT_W'(STORE_BYTES);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]  head0_reg, head0_next;
    logic [BYTE_W-1:0]  head1_reg, head1_next;
    logic [BYTE_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0]  prev_reg, prev_next;
    logic [BYTE_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]   fin_cnt_reg, fin_cnt_next;
    status_t            fin_status_reg, fin_status_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    status_t            status_reg, status_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               rx_open;
    logic               rx_take;
    logic               hex_mode;
    logic [CNT_W-1:0]   cnt_inc;
    logic [LIMIT_W-1:0] limit;
    logic [BYTE_W-1:0]  tail_last_sel;
    logic [ADDR_W-1:0]  addr_step2;
    logic [ADDR_W-1:0]  addr_step1;

    assign out_free      = !out_valid_reg || !res_stall;
    assign rx_open       = (state_reg == S_IDLE) || (state_reg == S_HEX_RX)
                           || (state_reg == S_TEXT_RX);
    assign rx_stall      = !(rx_open && out_free);
    assign rx_take       = rx_valid && !rx_stall;
    assign hex_mode      = (state_reg == S_HEX_RX);
    assign cnt_inc       = count_reg + CNT_W'(1);
    assign limit         = (cfg.frame_limit < STORE_LIMIT) ? cfg.frame_limit : STORE_LIMIT;
    assign tail_last_sel = hex_mode ? cfg.hex_tail_last : cfg.text_tail_last;
    assign addr_step1    = addr_reg + ADDR_W'(1);
    assign addr_step2    = addr_reg + ADDR_W'(2);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head0_next      = head0_reg;
        head1_next      = head1_reg;
        len_next        = len_reg;
        prev_next       = prev_reg;
        hi_next         = hi_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        fin_cnt_next    = fin_cnt_reg;
        fin_status_next = fin_status_reg;
        out_valid_next  = out_valid_reg && res_stall;
        kind_next       = kind_reg;
        data_next       = data_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_wdata       = rx_byte;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_take)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STATUS;
                    data_next      = '0;
                    last_next      = 1'b1;
                    count_next     = '0;
                    if (rx_byte == cfg.hex_start || rx_byte == cfg.text_start)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        count_next  = CNT_W'(1);
                        head0_next  = rx_byte;
                        prev_next   = rx_byte;
                        status_next = ST_BUSY;
                        state_next  = (rx_byte == cfg.hex_start) ? S_HEX_RX : S_TEXT_RX;
                    end
                    else
                    begin
                        status_next = ST_WAIT;
                    end
                end
            end
            S_HEX_RX, S_TEXT_RX:
            begin
                if (rx_take)
                begin
                    mem_we     = 1'b1;
                    count_next = cnt_inc;
                    if (count_reg == CNT_W'(1))
                    begin
                        head1_next = rx_byte;
                    end
                    if (count_reg == CNT_W'(2))
                    begin
                        len_next = rx_byte;
                    end
                    if (rx_byte == tail_last_sel)
                    begin
                        if (hex_mode)
                        begin
                            state_next = S_HEX_CHK;
                        end
                        else if (head0_reg != cfg.text_start)
                        begin
                            fin_cnt_next    = '0;
                            fin_status_next = ST_TEXT_ERR;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            addr_next  = ADDR_W'(1);
                            state_next = S_TXT_RD;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_STATUS;
                        data_next      = '0;
                        last_next      = 1'b1;
                        prev_next      = rx_byte;
                        if (LIMIT_W'(cnt_inc) >= limit)
                        begin
                            status_next = hex_mode ? ST_HEX_ERR : ST_TEXT_ERR;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            status_next = ST_BUSY;
                        end
                    end
                end
            end
            S_HEX_CHK:
            begin
                fin_cnt_next = '0;
                state_next   = S_FIN;
                if (head0_reg != cfg.hex_start || head1_reg != cfg.hex_second_start)
                begin
                    fin_status_next = ST_HEAD_ERR;
                end
                else if (count_reg < CNT_W'(HEX_OVERHEAD)
                         || (9'(len_reg) + 9'(HEX_OVERHEAD)) != 9'(count_reg)
                         || prev_reg != cfg.hex_tail_first)
                begin
                    fin_status_next = ST_HEX_ERR;
                end
                else
                begin
                    fin_status_next = ST_HEX_OK;
                    fin_cnt_next    = CNT_W'(len_reg[BYTE_W-1:1]);
                    addr_next       = ADDR_W'(HEX_PAY_OFS);
                    end_next        = ADDR_W'(len_reg & 8'hFE) + ADDR_W'(HEX_PAY_OFS);
                    if (len_reg[BYTE_W-1:1] != '0)
                    begin
                        state_next = S_HEX_RDH;
                    end
                end
            end
            S_HEX_RDH:
            begin
                mem_re     = 1'b1;
                state_next = S_HEX_RDL;
            end
            S_HEX_RDL:
            begin
                mem_re     = 1'b1;
                mem_raddr  = addr_step1;
                hi_next    = mem_rdata;
                state_next = S_HEX_EMIT;
            end
            S_HEX_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_HEX;
                    data_next      = {hi_reg, mem_rdata};
                    status_next    = ST_HEX_OK;
                    last_next      = 1'b0;
                    addr_next      = addr_step2;
                    state_next     = (addr_step2 == end_reg) ? S_FIN : S_HEX_RDH;
                end
            end
            S_TXT_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_TXT_CMP;
            end
            S_TXT_CMP:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_step1;
                if ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg)
                begin
                    fin_cnt_next    = '0;
                    fin_status_next = ST_TEXT_ERR;
                    state_next      = S_FIN;
                end
                else if (mem_rdata == cfg.text_tail_first)
                begin
                    end_next   = addr_reg;
                    state_next = S_TXT_CMP2;
                end
                else
                begin
                    addr_next = addr_step1;
                end
            end
            S_TXT_CMP2:
            begin
                state_next = S_FIN;
                if (mem_rdata == cfg.text_tail_last)
                begin
                    fin_status_next = ST_TEXT_OK;
                    fin_cnt_next    = CNT_W'(end_reg) - CNT_W'(1);
                    addr_next       = ADDR_W'(1);
                    if (end_reg != ADDR_W'(1))
                    begin
                        state_next = S_TXT_ERD;
                    end
                end
                else
                begin
                    fin_status_next = ST_TEXT_ERR;
                    fin_cnt_next    = '0;
                end
            end
            S_TXT_ERD:
            begin
                mem_re     = 1'b1;
                state_next = S_TXT_EMIT;
            end
            S_TXT_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TEXT;
                    data_next      = DATA_W'(mem_rdata);
                    status_next    = ST_TEXT_OK;
                    last_next      = 1'b0;
                    addr_next      = addr_step1;
                    state_next     = (addr_step1 == end_reg) ? S_FIN : S_TXT_ERD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STATUS;
                    data_next      = DATA_W'(fin_cnt_reg);
                    status_next    = fin_status_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head0_reg      <= head0_next;
        head1_reg      <= head1_next;
        len_reg        <= len_next;
        prev_reg       <= prev_next;
        hi_reg         <= hi_next;
        addr_reg       <= addr_next;
        end_reg        <= end_next;
        fin_cnt_reg    <= fin_cnt_next;
        fin_status_reg <= fin_status_next;
        kind_reg       <= kind_next;
        data_reg       <= data_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign res_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ----- src/dpfr_checker.sv -----
// port-level checker of the frame receiver and its bind
module dpfr_checker
    import dpfr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rx_stall,
    input logic              res_valid,
    input logic              res_stall,
    input logic [1:0]        kind,
    input logic [DATA_W-1:0] data,
    input logic [2:0]        status,
    input logic              last
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result beat dropped while stalled");

    a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_STATUS |-> !last)
        else $error("payload beat marked last");

    a_hex_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_HEX |-> status == ST_HEX_OK)
        else $error("binary word without ok code");

    a_text_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_TEXT |-> status == ST_TEXT_OK && data[15:8] == 8'h00)
        else $error("bad text payload beat");

    a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> rx_stall)
        else $error("byte taken during payload walk");

endmodule

bind dual_protocol_frame_receiver dpfr_checker u_dpfr_checker (.*);
